/* rtl/gn2d_pkg.sv */
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types, constants and helpers for the 2-D gradient noise block.
// ----------------------------------------------------------------------------
package gn2d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int HALF       = 1 << (FRAC_BITS - 1);
    localparam int BYTE_BITS  = 8;

    // Fade intermediates, gradients, interpolated values and products
    localparam int FADE_W = FRAC_BITS + 8;
    localparam int GRAD_W = FRAC_BITS + 3;
    localparam int LERP_W = FRAC_BITS + 4;
    localparam int PROD_W = 2 * FRAC_BITS + 8;

    // Gradient selection from the low hash bits
    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_NP = 2'd1;
    localparam logic [1:0] GRAD_PN = 2'd2;
    localparam logic [1:0] GRAD_NN = 2'd3;

    typedef logic [TABLE_BITS-1:0]    idx_t;
    typedef logic [BYTE_BITS-1:0]     byte_t;
    typedef logic [FRAC_BITS-1:0]     frac_t;
    typedef logic [FRAC_BITS:0]       wt_t;
    typedef logic signed [FADE_W-1:0] fade_t;
    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic signed [LERP_W-1:0] lerp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [FRAC_BITS+1:0] noise_t;

    typedef struct packed {
        logic  en;
        idx_t  idx;
        byte_t val;
    } wr_t;

    // Round a Q.2F product back to Q.F, ties toward plus infinity
    function automatic prod_t round_q(input prod_t p);
        prod_t s;
        s = p + prod_t'(HALF);
        return s >>> FRAC_BITS;
    endfunction

    function automatic grad_t grad(input logic [1:0] h, input grad_t dx, input grad_t dy);
        grad_t g;
        case (h)
            GRAD_PP: g = dx + dy;
            GRAD_NP: g = dy - dx;
            GRAD_PN: g = dx - dy;
            default: g = -dx - dy;
        endcase
        return g;
    endfunction

endpackage

/* rtl/gn2d_if.sv */
// ----------------------------------------------------------------------------
// gn2d_if
// Valid/ready channels of the 2-D gradient noise block.
// ----------------------------------------------------------------------------
interface gn2d_in_if
    import gn2d_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]        entry_index;
    logic [7:0]        entry_value;

    modport source (output valid, cmd, x_coord, y_coord, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, cmd, x_coord, y_coord, entry_index, entry_value,
                    output ready);
endinterface

interface gn2d_out_if
    import gn2d_pkg::*;
    ();
    logic   valid;
    logic   ready;
    noise_t noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

/* rtl/gn2d_ram.sv */
// ----------------------------------------------------------------------------
// gn2d_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/gn2d_fade.sv */
// ----------------------------------------------------------------------------
// gn2d_fade
// Quintic fade weight 6t^5 - 15t^4 + 10t^3 by Horner steps, five stages.
// ----------------------------------------------------------------------------
module gn2d_fade
    import gn2d_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  frac_t t,
    output wt_t   w
);

    frac_t t1_reg, t2_reg, t3_reg;
    prod_t p1_reg, p2_reg, p3_reg, p4_reg;
    wt_t   w_reg;
    fade_t a0, b1, c2, d3;
    prod_t e4;
    wt_t   w_next;

    always_comb
    begin
        a0 = fade_t'(6 * int'(t) - 15 * ONE);
        b1 = fade_t'(round_q(p1_reg)) + fade_t'(10 * ONE);
        c2 = fade_t'(round_q(p2_reg));
        d3 = fade_t'(round_q(p3_reg));
        e4 = round_q(p4_reg);
        // clamp to 0 .. 1.0
        if (e4 < 0)
            w_next = '0;
        else if (e4 > prod_t'(ONE))
            w_next = wt_t'(ONE);
        else
            w_next = wt_t'(e4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            p1_reg <= $signed({1'b0, t}) * a0;
            p2_reg <= $signed({1'b0, t1_reg}) * b1;
            p3_reg <= $signed({1'b0, t2_reg}) * c2;
            p4_reg <= $signed({1'b0, t3_reg}) * d3;
            w_reg  <= w_next;
        end
    end

    assign w = w_reg;

endmodule

/* rtl/gn2d_hash.sv */
// ----------------------------------------------------------------------------
// gn2d_hash
// Chained permutation lookups over five table copies, three stages.
// ----------------------------------------------------------------------------
module gn2d_hash
    import gn2d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  wr_t   wr,
    input  idx_t  cx,
    input  idx_t  cy,
    output byte_t h00,
    output byte_t h10,
    output byte_t h01,
    output byte_t h11
);

    wr_t   s1_wr_reg, s2_wr_reg;
    idx_t  s1_cy_reg;
    byte_t p0, p1, aa, ab, ba, bb;
    idx_t  a, b;

    // Table writes ride the pipe so every copy sees them in item order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_wr_reg <= '0;
            s2_wr_reg <= '0;
        end
        else if (en)
        begin
            s1_wr_reg <= wr;
            s2_wr_reg <= s1_wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cy_reg <= cy;
        end
    end

    assign a = idx_t'(p0) + s1_cy_reg;
    assign b = idx_t'(p1) + s1_cy_reg;

    gn2d_ram #(.WIDTH(BYTE_BITS), .DEPTH(TABLE_SIZE)) u_ram_cell (
        .clk(clk), .we(en && wr.en), .waddr(wr.idx), .wdata(wr.val), .re(en),
        .raddr_a(cx), .raddr_b(cx + 1'b1), .rdata_a(p0), .rdata_b(p1)
    );

    gn2d_ram #(.WIDTH(BYTE_BITS), .DEPTH(TABLE_SIZE)) u_ram_a (
        .clk(clk), .we(en && s1_wr_reg.en), .waddr(s1_wr_reg.idx),
        .wdata(s1_wr_reg.val), .re(en),
        .raddr_a(a), .raddr_b(a + 1'b1), .rdata_a(aa), .rdata_b(ab)
    );

    gn2d_ram #(.WIDTH(BYTE_BITS), .DEPTH(TABLE_SIZE)) u_ram_b (
        .clk(clk), .we(en && s1_wr_reg.en), .waddr(s1_wr_reg.idx),
        .wdata(s1_wr_reg.val), .re(en),
        .raddr_a(b), .raddr_b(b + 1'b1), .rdata_a(ba), .rdata_b(bb)
    );

    gn2d_ram #(.WIDTH(BYTE_BITS), .DEPTH(TABLE_SIZE)) u_ram_ga (
        .clk(clk), .we(en && s2_wr_reg.en), .waddr(s2_wr_reg.idx),
        .wdata(s2_wr_reg.val), .re(en),
        .raddr_a(idx_t'(aa)), .raddr_b(idx_t'(ab)), .rdata_a(h00), .rdata_b(h01)
    );

    gn2d_ram #(.WIDTH(BYTE_BITS), .DEPTH(TABLE_SIZE)) u_ram_gb (
        .clk(clk), .we(en && s2_wr_reg.en), .waddr(s2_wr_reg.idx),
        .wdata(s2_wr_reg.val), .re(en),
        .raddr_a(idx_t'(ba)), .raddr_b(idx_t'(bb)), .rdata_a(h10), .rdata_b(h11)
    );

endmodule

/* rtl/gradient_noise_2d.sv */
// ----------------------------------------------------------------------------
// gradient_noise_2d
// Two-dimensional Perlin gradient noise, signed Q16.16 in, Q2.16 out.
// ----------------------------------------------------------------------------
// Input channel: a word with cmd 0 stores entry_value at entry_index of the
// permutation table; a word with cmd 1 evaluates noise at (x_coord, y_coord).
// Load all table entries before the first evaluation.
// Output channel: one noise_value word per evaluate word, none per write.
// Throughput: one word per cycle while the output is not stalled; the
// nine-stage pipeline is paced by one multiply per stage in the fade and
// interpolation paths, and the three chained table lookups use their own
// dual-read table copies, one for the first lookup and two for each other.
// The whole pipe advances when the output register is empty or taken;
// a stalled receiver freezes every stage and holds ready low, so nothing
// is dropped or repeated.
// Reset clears all valid bits; table contents are kept until rewritten.
// ----------------------------------------------------------------------------
module gradient_noise_2d
    import gn2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    gn2d_in_if.sink           in_ch,
    gn2d_out_if.source        out_ch
);

    localparam int PIPE = 8;

    logic            adv, fire;
    wr_t             wr;
    frac_t           fx, fy;
    wt_t             u, v;
    byte_t           h00, h10, h01, h11;

    logic [PIPE:1]   ev_reg;
    logic            out_valid_reg;
    frac_t           fx1_reg, fx2_reg, fx3_reg, fy1_reg, fy2_reg, fy3_reg;
    grad_t           g00_4_reg, g10_4_reg, g01_4_reg, g11_4_reg;
    grad_t           g00_5_reg, g10_5_reg, g01_5_reg, g11_5_reg;
    prod_t           pl0_6_reg, pl1_6_reg;
    grad_t           g00_6_reg, g01_6_reg;
    wt_t             v6_reg, v7_reg;
    lerp_t           x0_7_reg, x1_7_reg, x0_8_reg;
    prod_t           pf_8_reg;
    noise_t          noise_reg;

    grad_t           dx0, dx1, dy0, dy1;
    lerp_t           x0_next, x1_next, r_next;
    noise_t          noise_next;

    assign adv  = !out_valid_reg || out_ch.ready;
    assign fire = in_ch.valid && adv;
    assign in_ch.ready = adv;

    assign fx = in_ch.x_coord[FRAC_BITS-1:0];
    assign fy = in_ch.y_coord[FRAC_BITS-1:0];

    always_comb
    begin
        wr.en  = fire && !in_ch.cmd;
        wr.idx = idx_t'(in_ch.entry_index);
        wr.val = in_ch.entry_value;
    end

    gn2d_hash u_hash (
        .clk(clk), .rst_n(rst_n), .en(adv), .wr(wr),
        .cx(in_ch.x_coord[FRAC_BITS +: TABLE_BITS]),
        .cy(in_ch.y_coord[FRAC_BITS +: TABLE_BITS]),
        .h00(h00), .h10(h10), .h01(h01), .h11(h11)
    );

    gn2d_fade u_fade_x (.clk(clk), .en(adv), .t(fx), .w(u));
    gn2d_fade u_fade_y (.clk(clk), .en(adv), .t(fy), .w(v));

    always_comb
    begin
        dx0 = grad_t'($signed({1'b0, fx3_reg}));
        dy0 = grad_t'($signed({1'b0, fy3_reg}));
        dx1 = dx0 - grad_t'(ONE);
        dy1 = dy0 - grad_t'(ONE);

        x0_next = lerp_t'(g00_6_reg) + lerp_t'(round_q(pl0_6_reg));
        x1_next = lerp_t'(g01_6_reg) + lerp_t'(round_q(pl1_6_reg));
        r_next  = x0_8_reg + lerp_t'(round_q(pf_8_reg));

        // saturate to -1.0 .. +1.0
        if (r_next > lerp_t'(ONE))
            noise_next = noise_t'(ONE);
        else if (r_next < -lerp_t'(ONE))
            noise_next = -noise_t'(ONE);
        else
            noise_next = noise_t'(r_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ev_reg        <= {ev_reg[PIPE-1:1], fire && in_ch.cmd};
            out_valid_reg <= ev_reg[PIPE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx1_reg <= fx;
            fx2_reg <= fx1_reg;
            fx3_reg <= fx2_reg;
            fy1_reg <= fy;
            fy2_reg <= fy1_reg;
            fy3_reg <= fy2_reg;

            g00_4_reg <= grad(h00[1:0], dx0, dy0);
            g10_4_reg <= grad(h10[1:0], dx1, dy0);
            g01_4_reg <= grad(h01[1:0], dx0, dy1);
            g11_4_reg <= grad(h11[1:0], dx1, dy1);

            // hold gradients until the fade weights arrive
            g00_5_reg <= g00_4_reg;
            g10_5_reg <= g10_4_reg;
            g01_5_reg <= g01_4_reg;
            g11_5_reg <= g11_4_reg;

            pl0_6_reg <= $signed({1'b0, u}) * (lerp_t'(g10_5_reg) - lerp_t'(g00_5_reg));
            pl1_6_reg <= $signed({1'b0, u}) * (lerp_t'(g11_5_reg) - lerp_t'(g01_5_reg));
            g00_6_reg <= g00_5_reg;
            g01_6_reg <= g01_5_reg;
            v6_reg    <= v;

            x0_7_reg <= x0_next;
            x1_7_reg <= x1_next;
            v7_reg   <= v6_reg;

            pf_8_reg <= $signed({1'b0, v7_reg}) * (x1_7_reg - x0_7_reg);
            x0_8_reg <= x0_7_reg;

            noise_reg <= noise_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.noise_value = noise_reg;

endmodule

/* tb/sv/gradient_noise_2d_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_tb
// Loads the permutation table, then sends evaluate words with directed and
// random coordinates. A local fixed-point noise calculation predicts each
// result; results are checked in order against the queue of predictions.
// ----------------------------------------------------------------------------
module gradient_noise_2d_tb;
    import gn2d_pkg::*;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;
    localparam int   LIMIT     = 400000;
    localparam int   LATENCY   = 9;

    logic clk;
    logic rst_n;

    gn2d_in_if  in_ch ();
    gn2d_out_if out_ch ();

    gradient_noise_2d DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    byte_t             perm_copy [TABLE_SIZE];
    logic signed [17:0] noise_expected [$];
    int                errors;
    int                cycles;
    int                long_hold;
    bit                bursty;
    int                burst_left;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("gradient_noise_2d test failed");
            $finish;
        end
    end

    // Q.16 product rounded to nearest, ties up
    function automatic longint mul_rnd(longint a, longint b);
        return (a * b + (64'sd1 <<< 15)) >>> 16;
    endfunction

    function automatic longint fade_weight(longint t);
        longint a, b, c, d, e;
        a = 6 * t - 15 * 65536;
        b = mul_rnd(t, a) + 10 * 65536;
        c = mul_rnd(t, b);
        d = mul_rnd(t, c);
        e = mul_rnd(t, d);
        if (e < 0) e = 0;
        if (e > 65536) e = 65536;
        return e;
    endfunction

    function automatic longint corner_dot(byte_t h, longint dx, longint dy);
        case (h[1:0])
            GRAD_PP: return dx + dy;
            GRAD_NP: return dy - dx;
            GRAD_PN: return dx - dy;
            default: return -dx - dy;
        endcase
    endfunction

    function automatic logic signed [17:0] noise_at(logic signed [31:0] xc,
                                                     logic signed [31:0] yc);
        idx_t   cx, cy, a, b, aa, ab, ba, bb;
        longint fx, fy, u, v, g00, g10, g01, g11, r0, r1, r;
        cx = xc[23:16];
        cy = yc[23:16];
        fx = longint'(xc[15:0]);
        fy = longint'(yc[15:0]);
        u  = fade_weight(fx);
        v  = fade_weight(fy);
        a  = perm_copy[cx] + cy;
        b  = perm_copy[idx_t'(cx + 1)] + cy;
        aa = perm_copy[a];
        ab = perm_copy[idx_t'(a + 1)];
        ba = perm_copy[b];
        bb = perm_copy[idx_t'(b + 1)];
        g00 = corner_dot(perm_copy[aa], fx, fy);
        g10 = corner_dot(perm_copy[ba], fx - 65536, fy);
        g01 = corner_dot(perm_copy[ab], fx, fy - 65536);
        g11 = corner_dot(perm_copy[bb], fx - 65536, fy - 65536);
        r0 = g00 + mul_rnd(u, g10 - g00);
        r1 = g01 + mul_rnd(u, g11 - g01);
        r  = r0 + mul_rnd(v, r1 - r0);
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        return r[17:0];
    endfunction

    // Receiver: random stalls, with an occasional long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (long_hold > 0)
        begin
            out_ch.ready <= 1'b0;
            long_hold    <= long_hold - 1;
        end
        else
            out_ch.ready <= bursty ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (noise_expected.size() == 0)
            begin
                $display("%0t: unexpected noise word %0d", $time, out_ch.noise_value);
                errors++;
            end
            else
            begin
                if (noise_expected[0] !== out_ch.noise_value)
                begin
                    $display("%0t: noise_value expected %0d actual %0d", $time,
                             noise_expected[0], out_ch.noise_value);
                    errors++;
                end
                void'(noise_expected.pop_front());
            end
        end
    end

    task automatic send_word(logic c, logic signed [31:0] xc, logic signed [31:0] yc,
                             byte_t ix, byte_t vl);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= c;
        in_ch.x_coord     <= xc;
        in_ch.y_coord     <= yc;
        in_ch.entry_index <= ix;
        in_ch.entry_value <= vl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (c == CMD_WRITE)
            perm_copy[ix] = vl;
        else
            noise_expected.push_back(noise_at(xc, yc));
        @(negedge clk);
    endtask

    task automatic evaluate(logic signed [31:0] xc, logic signed [31:0] yc);
        send_word(CMD_EVAL, xc, yc, byte_t'($urandom), byte_t'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (noise_expected.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic test_table_load(bit shuffled);
        byte_t vals [TABLE_SIZE];
        int    j;
        byte_t t;
        for (int i = 0; i < TABLE_SIZE; i++) vals[i] = byte_t'(i);
        if (shuffled)
            for (int i = TABLE_SIZE - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = vals[i]; vals[i] = vals[j]; vals[j] = t;
            end
        for (int i = 0; i < TABLE_SIZE; i++)
            send_word(CMD_WRITE, $urandom, $urandom, byte_t'(i), vals[i]);
    endtask

    task automatic test_directed();
        evaluate(32'sh0000_0000, 32'sh0000_0000);
        evaluate(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        evaluate(32'sh8000_0000, 32'sh8000_0000);
        evaluate(32'sh7FFF_FFFF, 32'sh8000_0000);
        evaluate(32'sh0000_8000, 32'sh0000_8000);
        evaluate(32'sh0000_FFFF, 32'sh0000_0001);
        evaluate(-32'sd1, -32'sd65536);
        evaluate(-32'sd98304, 32'sd163840);
        evaluate(32'sh00FF_C000, 32'sh00FF_4000);   // cell wrap at 255
        evaluate(32'shFF00_0000, 32'sh0100_8000);
        evaluate(32'h5555_5555, 32'hAAAA_AAAA);
        evaluate(32'hAAAA_AAAA, 32'h5555_5555);
        // overwrite single entries, including the extremes of index and value
        send_word(CMD_WRITE, 0, 0, 8'd0, 8'd255);
        send_word(CMD_WRITE, 0, 0, 8'd255, 8'd0);
        evaluate(32'sh00FF_1234, 32'sh0000_ABCD);
        evaluate(32'sh0000_1234, 32'sh00FF_ABCD);
    endtask

    task automatic test_random(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_word(CMD_WRITE, $urandom, $urandom, byte_t'($urandom),
                          byte_t'($urandom));
            else if (r < 4)
                evaluate($urandom, $urandom);
            else
                evaluate($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000,
                         $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
        end
    endtask

    task automatic test_backpressure();
        long_hold = 200;
        for (int n = 0; n < 60; n++) evaluate($urandom, $urandom);
    endtask

    initial
    begin
        errors      = 0;
        cycles      = 0;
        long_hold   = 0;
        bursty      = 1'b0;
        burst_left  = 0;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd   = CMD_WRITE;
        in_ch.x_coord     = '0;
        in_ch.y_coord     = '0;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_table_load(1'b0);
        test_directed();
        drain();
        bursty = 1'b1;
        test_table_load(1'b1);
        test_random(600);
        test_backpressure();
        bursty = 1'b0;
        test_random(300);
        bursty = 1'b1;
        test_random(700);
        drain();

        if (errors == 0)
            $display("gradient_noise_2d test passed");
        else
            $display("gradient_noise_2d test failed");
        $finish;
    end

endmodule
